// ===== sv/sltrie_pkg.sv =====
// Shared types and constants of the sibling-list trie engine.
package sltrie_pkg;

    // Fixed widths of the stream payload
    localparam int unsigned SYMBOL_W    = 8;
    localparam int unsigned NEW_ID_W    = 16;
    localparam int unsigned S_TDATA_W   = 24;
    localparam int unsigned RESULT_ID_W = 16;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned M_TDATA_W   = 24;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // One result word
    typedef struct packed {
        logic                   existed;
        logic [STATUS_W-1:0]    status;
        logic [RESULT_ID_W-1:0] result_id;
    } sltrie_result_t;

    // Per-field write enables of the node memory
    typedef struct packed {
        logic sym;
        logic next;
        logic child;
        logic id;
        logic has;
    } sltrie_wen_t;

endpackage

// ===== sv/sibling_list_trie_engine_unit.sv =====
// Top level of the sibling-list trie engine: node store, sequencer and result register.
//
// Keys stream in one symbol per word (tuser = insert, tlast = final symbol) and
// walk a first-child/next-sibling trie held in a node memory of MAX_NODES
// entries (one read and one write port) with a registered read. A symbol is
// accepted, then the current node is read to fetch its first child when the
// cursor is not the root, then siblings are compared (the memory read port
// checks one sibling per cycle), then a node is appended if needed (entry write,
// then link write); a symbol of a key already appending goes straight to the
// append, and one of a key already marked not found or overflowed reads no
// node. The final symbol then hands its result to the output register, waiting
// while that register still holds an unaccepted result; once handed over, the next key can start
// while the result waits. No clearing pass is needed after reset: the root's
// child link sits in a register and nodes beyond the fill count are never read.
module sibling_list_trie_engine_unit #(
    parameter int unsigned MAX_NODES   = 4096,
    parameter int unsigned SYMBOL_BITS = 8,
    parameter int unsigned ID_BITS     = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] symbol, [23:8] new_id
    input  logic [sltrie_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                               s_axis_tlast,
    // [0] mode (1 = insert)
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] result_id, [17:16] status, [18] existed, [23:19] zero
    output logic [sltrie_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import sltrie_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_NODES);
    localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
    localparam int unsigned SYM_W = (SYMBOL_BITS < SYMBOL_W) ? SYMBOL_BITS : SYMBOL_W;
    localparam int unsigned ID_W  = (ID_BITS < NEW_ID_W) ? ID_BITS : NEW_ID_W;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [SYM_W-1:0] rd_sym;
    logic [IDX_W-1:0] rd_next;
    logic [IDX_W-1:0] rd_child;
    logic [ID_W-1:0]  rd_id;
    logic             rd_has;
    sltrie_wen_t      wen;
    logic [IDX_W-1:0] wr_addr;
    logic [SYM_W-1:0] wr_sym;
    logic [IDX_W-1:0] wr_next;
    logic [IDX_W-1:0] wr_child;
    logic [ID_W-1:0]  wr_id;
    logic             wr_has;
    logic             res_load;
    sltrie_result_t   res;
    logic             out_free;

    sltrie_node_mem #(
        .DEPTH (MAX_NODES),
        .IDX_W (IDX_W),
        .SYM_W (SYM_W),
        .ID_W  (ID_W)
    ) u_node_mem (
        .aclk     (aclk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_sym   (rd_sym),
        .rd_next  (rd_next),
        .rd_child (rd_child),
        .rd_id    (rd_id),
        .rd_has   (rd_has),
        .wen      (wen),
        .wr_addr  (wr_addr),
        .wr_sym   (wr_sym),
        .wr_next  (wr_next),
        .wr_child (wr_child),
        .wr_id    (wr_id),
        .wr_has   (wr_has)
    );

    sltrie_ctrl #(
        .MAX_NODES (MAX_NODES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W),
        .SYM_W     (SYM_W),
        .ID_W      (ID_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_sym        (rd_sym),
        .rd_next       (rd_next),
        .rd_child      (rd_child),
        .rd_id         (rd_id),
        .rd_has        (rd_has),
        .wen           (wen),
        .wr_addr       (wr_addr),
        .wr_sym        (wr_sym),
        .wr_next       (wr_next),
        .wr_child      (wr_child),
        .wr_id         (wr_id),
        .wr_has        (wr_has),
        .res_load      (res_load),
        .res           (res),
        .out_free      (out_free)
    );

    sltrie_out_stage u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_load      (res_load),
        .res           (res),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== sv/sltrie_node_mem.sv =====
// Node store: one synchronous memory, one read and one write port, field write enables.
module sltrie_node_mem #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned IDX_W = 12,
    parameter int unsigned SYM_W = 8,
    parameter int unsigned ID_W  = 16
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [SYM_W-1:0]     rd_sym,
    output logic [IDX_W-1:0]     rd_next,
    output logic [IDX_W-1:0]     rd_child,
    output logic [ID_W-1:0]      rd_id,
    output logic                 rd_has,
    input  sltrie_pkg::sltrie_wen_t wen,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [SYM_W-1:0]     wr_sym,
    input  logic [IDX_W-1:0]     wr_next,
    input  logic [IDX_W-1:0]     wr_child,
    input  logic [ID_W-1:0]      wr_id,
    input  logic                 wr_has
);
    import sltrie_pkg::*;

    logic [SYM_W-1:0] sym_mem   [DEPTH];
    logic [IDX_W-1:0] next_mem  [DEPTH];
    logic [IDX_W-1:0] child_mem [DEPTH];
    logic [ID_W-1:0]  id_mem    [DEPTH];
    logic             has_mem   [DEPTH];

    // Field-masked write
    always_ff @(posedge aclk) begin
        if (wen.sym) begin
            sym_mem[wr_addr] <= wr_sym;
        end
        if (wen.next) begin
            next_mem[wr_addr] <= wr_next;
        end
        if (wen.child) begin
            child_mem[wr_addr] <= wr_child;
        end
        if (wen.id) begin
            id_mem[wr_addr] <= wr_id;
        end
        if (wen.has) begin
            has_mem[wr_addr] <= wr_has;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_sym   <= sym_mem[rd_addr];
            rd_next  <= next_mem[rd_addr];
            rd_child <= child_mem[rd_addr];
            rd_id    <= id_mem[rd_addr];
            rd_has   <= has_mem[rd_addr];
        end
    end

endmodule

// ===== sv/sltrie_out_stage.sv =====
// Result output register of the trie engine.
module sltrie_out_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               res_load,
    input  sltrie_pkg::sltrie_result_t         res,
    output logic                               out_free,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sltrie_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import sltrie_pkg::*;

    logic           valid_reg;
    sltrie_result_t data_reg;

    assign out_free = !valid_reg || m_axis_tready;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_load) begin
            valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (res_load) begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(data_reg);

endmodule

// ===== sv/sltrie_ctrl.sv =====
// Trie walk sequencer: sibling search, node append and result decision.
module sltrie_ctrl #(
    parameter int unsigned MAX_NODES = 4096,
    parameter int unsigned IDX_W     = 12,
    parameter int unsigned CNT_W     = 13,
    parameter int unsigned SYM_W     = 8,
    parameter int unsigned ID_W      = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input words
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sltrie_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                               s_axis_tlast,
    input  logic                               s_axis_tuser,
    // node memory
    output logic                               rd_en,
    output logic [IDX_W-1:0]                   rd_addr,
    input  logic [SYM_W-1:0]                   rd_sym,
    input  logic [IDX_W-1:0]                   rd_next,
    input  logic [IDX_W-1:0]                   rd_child,
    input  logic [ID_W-1:0]                    rd_id,
    input  logic                               rd_has,
    output sltrie_pkg::sltrie_wen_t            wen,
    output logic [IDX_W-1:0]                   wr_addr,
    output logic [SYM_W-1:0]                   wr_sym,
    output logic [IDX_W-1:0]                   wr_next,
    output logic [IDX_W-1:0]                   wr_child,
    output logic [ID_W-1:0]                    wr_id,
    output logic                               wr_has,
    // result
    output logic                               res_load,
    output sltrie_pkg::sltrie_result_t         res,
    input  logic                               out_free
);
    import sltrie_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_CHILD = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_LINK  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // Key phases
    localparam logic [1:0] PH_MATCHING  = 2'd0;
    localparam logic [1:0] PH_APPENDING = 2'd1;
    localparam logic [1:0] PH_NOT_FOUND = 2'd2;
    localparam logic [1:0] PH_OVERFLOW  = 2'd3;

    localparam logic [IDX_W-1:0] NO_NODE = '0;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] nodes_used_reg, nodes_used_next;
    logic [IDX_W-1:0] root_child_reg, root_child_next;

    // Item and walk payload
    logic             mode_reg, mode_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic             last_reg, last_next;
    logic [ID_W-1:0]  nid_reg, nid_next;
    logic [IDX_W-1:0] child_reg, child_next;
    logic [IDX_W-1:0] prev_reg, prev_next;
    sltrie_result_t   res_reg, res_next;

    // Intermediate decisions
    logic             probe, miss, add_req, finish;
    logic [IDX_W-1:0] probe_node, miss_prev, add_prev;
    logic [IDX_W-1:0] new_node;

    assign new_node = nodes_used_reg[IDX_W-1:0];

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cursor_next     = cursor_reg;
        nodes_used_next = nodes_used_reg;
        root_child_next = root_child_reg;
        mode_next       = mode_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        nid_next        = nid_reg;
        child_next      = child_reg;
        prev_next       = prev_reg;
        res_next        = res_reg;

        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = cursor_reg;
        wen           = '0;
        wr_addr       = new_node;
        wr_sym        = sym_reg;
        wr_next       = NO_NODE;
        wr_child      = NO_NODE;
        wr_id         = nid_reg;
        wr_has        = last_reg;
        res_load      = 1'b0;

        probe      = 1'b0;
        probe_node = NO_NODE;
        miss       = 1'b0;
        miss_prev  = NO_NODE;
        add_req    = 1'b0;
        add_prev   = NO_NODE;
        finish     = 1'b0;

        // Per-state actions
        case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    mode_next  = s_axis_tuser;
                    sym_next   = s_axis_tdata[SYM_W-1:0];
                    last_next  = s_axis_tlast;
                    nid_next   = s_axis_tdata[SYMBOL_W +: ID_W];
                    state_next = S_START;
                end
            end
            S_START: begin
                case (phase_reg)
                    PH_MATCHING: begin
                        if (cursor_reg == NO_NODE) begin
                            probe      = 1'b1;
                            probe_node = root_child_reg;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = cursor_reg;
                            state_next = S_CHILD;
                        end
                    end
                    PH_APPENDING: begin
                        add_req  = 1'b1;
                        add_prev = NO_NODE;
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_CHILD: begin
                probe      = 1'b1;
                probe_node = rd_child;
            end
            S_CMP: begin
                if (rd_sym == sym_reg) begin
                    // hit: descend
                    cursor_next = child_reg;
                    finish      = 1'b1;
                    if (rd_has) begin
                        res_next = '{existed: 1'b1, status: ST_OK,
                                     result_id: RESULT_ID_W'(rd_id)};
                    end else if (mode_reg) begin
                        // prefix without id: store the new id if the key ends here
                        wen.id   = last_reg;
                        wen.has  = last_reg;
                        wr_addr  = child_reg;
                        wr_has   = 1'b1;
                        res_next = '{existed: 1'b0, status: ST_OK,
                                     result_id: RESULT_ID_W'(nid_reg)};
                    end else begin
                        res_next = '{existed: 1'b0, status: ST_NOT_FOUND,
                                     result_id: '0};
                    end
                end else if (rd_next == NO_NODE) begin
                    miss      = 1'b1;
                    miss_prev = child_reg;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = rd_next;
                    child_next = rd_next;
                end
            end
            S_ADD: begin
                // new node, its id set if it ends the key
                wen     = '{sym: 1'b1, next: 1'b1, child: 1'b1, id: 1'b1, has: 1'b1};
                wr_addr = new_node;
                state_next = S_LINK;
            end
            S_LINK: begin
                if (prev_reg != NO_NODE) begin
                    wen.next = 1'b1;
                    wr_addr  = prev_reg;
                    wr_next  = new_node;
                end else if (cursor_reg == NO_NODE) begin
                    root_child_next = new_node;
                end else begin
                    wen.child = 1'b1;
                    wr_addr   = cursor_reg;
                    wr_child  = new_node;
                end
                cursor_next     = new_node;
                nodes_used_next = nodes_used_reg + CNT_W'(1);
                phase_next      = PH_APPENDING;
                res_next        = '{existed: 1'b0, status: ST_OK,
                                    result_id: RESULT_ID_W'(nid_reg)};
                finish          = 1'b1;
            end
            S_OUT: begin
                if (out_free) begin
                    res_load    = 1'b1;
                    cursor_next = NO_NODE;
                    phase_next  = PH_MATCHING;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Start of a sibling walk
        if (probe) begin
            if (probe_node == NO_NODE) begin
                miss      = 1'b1;
                miss_prev = NO_NODE;
            end else begin
                rd_en      = 1'b1;
                rd_addr    = probe_node;
                child_next = probe_node;
                state_next = S_CMP;
            end
        end

        // No matching sibling
        if (miss) begin
            if (mode_reg) begin
                add_req  = 1'b1;
                add_prev = miss_prev;
            end else begin
                phase_next = PH_NOT_FOUND;
                finish     = 1'b1;
            end
        end

        // Append request, refused when the store is full
        if (add_req) begin
            if (nodes_used_reg == CNT_W'(MAX_NODES)) begin
                phase_next = PH_OVERFLOW;
                finish     = 1'b1;
            end else begin
                prev_next  = add_prev;
                state_next = S_ADD;
            end
        end

        // End of the item
        if (finish) begin
            if (phase_next == PH_NOT_FOUND) begin
                res_next = '{existed: 1'b0, status: ST_NOT_FOUND, result_id: '0};
            end else if (phase_next == PH_OVERFLOW) begin
                res_next = '{existed: 1'b0, status: ST_OVERFLOW, result_id: '0};
            end
            state_next = last_reg ? S_OUT : S_IDLE;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_MATCHING;
            cursor_reg     <= NO_NODE;
            nodes_used_reg <= CNT_W'(1);
            root_child_reg <= NO_NODE;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            cursor_reg     <= cursor_next;
            nodes_used_reg <= nodes_used_next;
            root_child_reg <= root_child_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        sym_reg   <= sym_next;
        last_reg  <= last_next;
        nid_reg   <= nid_next;
        child_reg <= child_next;
        prev_reg  <= prev_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

`ifndef NO_ASSERTIONS
    // cursor always names a node that exists
    a_cursor_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(cursor_reg) < nodes_used_reg)
        else $error("cursor beyond allocated nodes");

    // fill count stays within the store
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nodes_used_reg != '0 && nodes_used_reg <= CNT_W'(MAX_NODES))
        else $error("node fill count out of range");

    // each link step allocates exactly one node
    a_alloc_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LINK |=> nodes_used_reg == $past(nodes_used_reg) + CNT_W'(1))
        else $error("node allocation count slipped");

    // a first child under the root lands in the root link register
    a_root_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LINK && prev_reg == NO_NODE && cursor_reg == NO_NODE)
        |=> root_child_reg != NO_NODE)
        else $error("root link not set");

    // a result is only handed over for the final symbol of a key
    a_result_last: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> last_reg && state_reg == S_OUT)
        else $error("result for a non-final symbol");
`endif

endmodule
